FILE: sv/assert_macros.svh
// assertion macros shared by the circle rasterizer modules
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/cr_pkg.sv
// shared widths, codes and the group record for the circle rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cr_pkg;

	localparam int CB = 16;            // coordinate width
	localparam int XW = CB;            // step x
	localparam int YW = CB + 1;        // step y, signed
	localparam int DW = CB + 5;        // decision, signed
	localparam int PW = CB + 1;        // pixel coordinate, signed
	localparam int RW = CB - 1;        // radius

	localparam int IN_TDATA_W  = ((2 * CB + RW + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * PW + 7) / 8) * 8;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// decision rule constants
	localparam logic [DW-1:0] D_INIT  = DW'(3);
	localparam logic [DW-1:0] D_STRT  = DW'(6);
	localparam logic [DW-1:0] D_DIAG  = DW'(10);

	localparam logic [2:0] LAST_IDX = 3'd7;

	typedef struct packed {
		logic [XW-1:0]        x;
		logic signed [YW-1:0] y;
		logic signed [CB-1:0] cx;
		logic signed [CB-1:0] cy;
		logic                 done;
	} group_t;

endpackage

`default_nettype wire

FILE: sv/cr_front.sv
// front end: accepts start/step words, runs the decision update, pushes a group
// depends on cr_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cr_front import cr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 op,
	input  wire logic signed [CB-1:0] center_x,
	input  wire logic signed [CB-1:0] center_y,
	input  wire logic [RW-1:0]        radius,
	input  wire logic                 q_full,
	output logic                      push,
	output group_t                    push_grp
);

	logic [XW-1:0]        x_q;
	logic signed [YW-1:0] y_q;
	logic [DW-1:0]        d_q;
	logic signed [CB-1:0] cx_q, cy_q;
	logic                 active_q;

	logic [XW-1:0]  x_inc, nx;
	logic [YW-1:0]  y_dec, ny;
	logic [DW-1:0]  x_ext, y_dec_ext, r_ext, d_a, d_b, d_start, nd;
	logic           is_start, done;
	logic signed [CB-1:0] ncx, ncy;

	assign in_ready = !q_full;
	assign is_start = (op == OP_START);
	assign push     = in_valid && in_ready && (is_start || active_q);

	always_comb begin
		x_inc     = x_q + 1'b1;
		y_dec     = y_q - 1'b1;
		x_ext     = {{(DW-XW){1'b0}}, x_inc};
		y_dec_ext = {{(DW-YW){y_dec[YW-1]}}, y_dec};
		r_ext     = {{(DW-RW){1'b0}}, radius};
		d_a       = d_q + (x_ext << 2) + D_STRT;
		d_b       = d_q + ((x_ext - y_dec_ext) << 2) + D_DIAG;
		d_start   = D_INIT - (r_ext << 1);
		if (is_start) begin
			nx  = '0;
			ny  = {{(YW-RW){1'b0}}, radius};
			nd  = d_start;
			ncx = center_x;
			ncy = center_y;
		end else begin
			nx  = x_inc;
			// negative decision keeps y
			ny  = d_q[DW-1] ? y_q : y_dec;
			nd  = d_q[DW-1] ? d_a : d_b;
			ncx = cx_q;
			ncy = cy_q;
		end
		done = $signed({{(YW+1-XW){1'b0}}, nx}) > $signed({ny[YW-1], ny});
		push_grp.x    = nx;
		push_grp.y    = ny;
		push_grp.cx   = ncx;
		push_grp.cy   = ncy;
		push_grp.done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			x_q      <= nx;
			y_q      <= ny;
			d_q      <= nd;
			cx_q     <= ncx;
			cy_q     <= ncy;
			active_q <= !done;
		end
	end

	`ASSERT_NEXT(a_done_idles, push && push_grp.done, !active_q)
	`ASSERT_IMPL(a_no_push_full, push, !q_full)

endmodule

`default_nettype wire

FILE: sv/cr_queue.sv
// two-entry group queue between the front end and the pixel emitter
// depends on cr_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cr_queue import cr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  group_t    push_grp,
	output logic      full,
	output logic      q_valid,
	output group_t    head,
	input  wire logic pop
);

	group_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	assign full    = (cnt_q == QCW'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= QCW'(QDEPTH))

endmodule

`default_nettype wire

FILE: sv/cr_back.sv
// back end: expands one group into eight symmetric pixels, one per cycle while m_tready holds
// depends on cr_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cr_back import cr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	input  group_t                      head,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // pixel_x, pixel_y
	output logic                        m_tlast,   // last_of_group
	output logic [0:0]                  m_tuser    // circle_done
);

	group_t      grp_q;
	logic        busy_q;
	logic [2:0]  k_q;
	logic        out_valid_q, last_q, done_q;
	logic [PW-1:0] px_q, py_q;

	group_t        cur;
	logic          adv, have;
	logic [PW-1:0] x_e, y_e, cx_e, cy_e, a, b, px, py;

	assign cur  = busy_q ? grp_q : head;
	assign have = busy_q || q_valid;
	assign adv  = !out_valid_q || m_tready;
	assign pop  = adv && !busy_q && q_valid;

	always_comb begin
		x_e  = {{(PW-XW){1'b0}}, cur.x};
		y_e  = cur.y;
		cx_e = {{(PW-CB){cur.cx[CB-1]}}, cur.cx};
		cy_e = {{(PW-CB){cur.cy[CB-1]}}, cur.cy};
		// upper four pixels swap the roles of x and y
		a    = k_q[2] ? y_e : x_e;
		b    = k_q[2] ? x_e : y_e;
		px   = k_q[0] ? cx_e - a : cx_e + a;
		py   = k_q[1] ? cy_e - b : cy_e + b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= have;
			if (have) begin
				k_q    <= k_q + 1'b1;
				busy_q <= (k_q != LAST_IDX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
		if (adv && have) begin
			px_q   <= px;
			py_q   <= py;
			last_q <= (k_q == LAST_IDX);
			done_q <= cur.done;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_TDATA_W'({py_q, px_q});
	assign m_tlast    = last_q;
	assign m_tuser[0] = done_q;

	`ASSERT_IMPL(a_idle_index, !busy_q, k_q == 3'd0)
	`ASSERT_NEXT(a_pop_starts, pop, busy_q && k_q == 3'd1)

endmodule

`default_nettype wire

FILE: sv/circle_rasterizer.sv
// midpoint circle rasterizer with eight-way symmetry
// with the emitter idle, an accepted start or active step word is written into the group queue,
// and its first pixel is then put on m_tdata through the emitter's output register
// the emitter gives eight pixels per start or active step word, one pixel a cycle while m_tready holds
// a step while idle is accepted and gives no pixels; the two-entry group queue
// lets the front end run ahead of a stalled pixel sink
// reset: asynchronous, clears the stepping state and the queue; block comes up idle
`timescale 1ns / 1ps
`default_nettype none

module circle_rasterizer import cr_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // center_x, center_y, radius
	input  wire logic [0:0]             s_tuser,   // operation
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // pixel_x, pixel_y
	output logic                        m_tlast,   // last_of_group
	output logic [0:0]                  m_tuser    // circle_done
);

	logic   push, full, q_valid, pop;
	group_t push_grp, head;

	cr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (s_tuser[0]),
		.center_x (s_tdata[CB-1:0]),
		.center_y (s_tdata[2*CB-1:CB]),
		.radius   (s_tdata[2*CB+RW-1:2*CB]),
		.q_full   (full),
		.push     (push),
		.push_grp (push_grp)
	);

	cr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.full     (full),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop)
	);

	cr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

FILE: tb/sv/circle_pixel_checker.sv
// pixel checker for the circle rasterizer: follows the accepted input words, works out
// the eight expected pixels of every group and compares them with the output stream
// depends on cr_pkg
`timescale 1ns / 1ps

module circle_pixel_checker import cr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // center_x, center_y, radius
	input  logic [0:0]             s_tuser,   // operation
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y
	input  logic                   m_tlast,   // last_of_group
	input  logic [0:0]             m_tuser,   // circle_done
	output int                     failures,
	output int                     pending
);

	typedef struct {
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
		logic                 last;
		logic                 done;
	} pixel_t;

	pixel_t pixel_q[$];

	// stepping state of the circle being traced
	logic [XW-1:0]        trace_x;
	logic signed [YW-1:0] trace_y;
	logic signed [DW-1:0] trace_d;
	logic signed [CB-1:0] trace_cx;
	logic signed [CB-1:0] trace_cy;
	logic                 tracing;

	initial failures = 0;
	initial pending = 0;

	task automatic trace_word(input logic op, input logic [IN_TDATA_W-1:0] word);
		int xi, yi, cxi, cyi, r;
		int px[8];
		int py[8];
		logic fin;
		pixel_t p;
		if (op == OP_START) begin
			trace_cx = word[CB-1:0];
			trace_cy = word[2*CB-1:CB];
			r = int'(word[2*CB +: RW]);
			trace_x = '0;
			trace_y = YW'(r);
			trace_d = DW'(3 - 2 * r);
		end else begin
			// a step with no circle running is swallowed
			if (!tracing)
				return;
			trace_x = trace_x + 1'b1;
			if (trace_d < 0) begin
				trace_d = DW'(int'(trace_d) + 4 * int'(trace_x) + 6);
			end else begin
				trace_y = YW'(trace_y - 1);
				trace_d = DW'(int'(trace_d) + 4 * (int'(trace_x) - int'(trace_y)) + 10);
			end
		end
		xi = int'(trace_x);
		yi = int'(trace_y);
		fin = xi > yi;
		tracing = !fin;
		cxi = int'(trace_cx);
		cyi = int'(trace_cy);
		px = '{cxi + xi, cxi - xi, cxi + xi, cxi - xi, cxi + yi, cxi - yi, cxi + yi, cxi - yi};
		py = '{cyi + yi, cyi + yi, cyi - yi, cyi - yi, cyi + xi, cyi + xi, cyi - xi, cyi - xi};
		for (int k = 0; k < 8; k++) begin
			p.px = PW'(px[k]);
			p.py = PW'(py[k]);
			p.last = (k == 7);
			p.done = fin;
			pixel_q.insert(pixel_q.size(), p);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		logic signed [PW-1:0] got_x, got_y;
		if (!arst_n) begin
			trace_x = '0;
			trace_y = '0;
			trace_d = '0;
			trace_cx = '0;
			trace_cy = '0;
			tracing = 1'b0;
			pixel_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				trace_word(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready) begin
				got_x = m_tdata[PW-1:0];
				got_y = m_tdata[2*PW-1:PW];
				if (pixel_q.size() == 0) begin
					$error("pixel word (%0d, %0d) with nothing expected", got_x, got_y);
					failures++;
				end else begin
					want = pixel_q.pop_front();
					if (got_x !== want.px) begin
						$error("pixel_x expected %0d actual %0d", want.px, got_x);
						failures++;
					end
					if (got_y !== want.py) begin
						$error("pixel_y expected %0d actual %0d", want.py, got_y);
						failures++;
					end
					if (m_tlast !== want.last) begin
						$error("last_of_group expected %0b actual %0b", want.last, m_tlast);
						failures++;
					end
					if (m_tuser[0] !== want.done) begin
						$error("circle_done expected %0b actual %0b", want.done, m_tuser[0]);
						failures++;
					end
				end
			end
		end
		pending = pixel_q.size();
	end

endmodule

FILE: tb/sv/circle_rasterizer_test.sv
// top of the circle rasterizer testbench: clock, reset, input words and sink stalls
// depends on cr_pkg, circle_rasterizer and circle_pixel_checker
`timescale 1ns / 1ps

module circle_rasterizer_test import cr_pkg::*; ();

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // center_x, center_y, radius
	logic [0:0]             s_tuser = '0;    // operation
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // pixel_x, pixel_y
	logic                   m_tlast;         // last_of_group
	logic [0:0]             m_tuser;         // circle_done

	int failures;
	int pending;
	int words_sent = 0;
	int gap_pct = 25;
	bit calm = 1'b0;
	bit squeeze = 1'b0;
	bit squeezed = 1'b0;

	circle_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	circle_pixel_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser), .failures(failures), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

	// pixel sink: random ready bursts, one long hold-off, steady at the end
	initial forever begin
		if (calm) begin
			m_tready <= 1'b1;
			@(posedge clk);
		end else if (squeeze && !squeezed) begin
			squeezed = 1'b1;
			m_tready <= 1'b0;
			repeat (300) @(posedge clk);
		end else begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, $urandom_range(0, 1) ? 8 : 60)) @(posedge clk);
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	end

	task automatic offer_word(input logic op, input logic signed [CB-1:0] cx,
			input logic signed [CB-1:0] cy, input logic [RW-1:0] r);
		if (!calm && $urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_TDATA_W'({r, cy, cx});
		// ready is stable by the falling edge; the word goes in at the next rising one
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		words_sent++;
	endtask

	// start word followed by a number of step words with junk payload
	task automatic draw_circle(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
			input logic [RW-1:0] r, input int steps);
		offer_word(OP_START, cx, cy, r);
		repeat (steps) offer_word(OP_STEP, CB'($urandom), CB'($urandom), RW'($urandom));
	endtask

	initial begin
		int n, pick;
		logic signed [CB-1:0] cx, cy;
		logic [RW-1:0] r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero radius, its ending step, then a step while idle
		draw_circle(16'sd0, 16'sd0, 15'd0, 2);
		draw_circle(16'sd32767, -16'sd32768, 15'd32767, 3);
		// restart while a circle is running
		draw_circle(-16'sd32768, 16'sd32767, 15'd32767, 0);
		draw_circle(16'sd1, -16'sd1, 15'd1, 2);
		draw_circle(-16'sd32768, -16'sd32768, 15'd5, 6);
		draw_circle(16'sd32767, 16'sd32767, 15'd0, 1);
		draw_circle(-16'sd1, 16'sd0, 15'd16384, 1);

		// the sink holds off while a full circle is offered
		squeeze = 1'b1;
		draw_circle(CB'($urandom), CB'($urandom), 15'd20, 17);

		while (words_sent < 400) begin
			if ($urandom_range(0, 7) == 0)
				gap_pct = $urandom_range(0, 2) * 25;
			if (words_sent >= 340)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			cx = CB'($urandom);
			cy = CB'($urandom);
			if (pick < 55) begin
				r = RW'($urandom_range(0, 24));
				n = r * 3 / 4 + $urandom_range(1, 3);
				draw_circle(cx, cy, r, n);
			end else if (pick < 65) begin
				r = RW'($urandom_range(25, 100));
				draw_circle(cx, cy, r, r * 3 / 4 + 2);
			end else if (pick < 82) begin
				// cut short or run past the end
				r = RW'($urandom_range(0, 24));
				draw_circle(cx, cy, r, $urandom_range(0, r + 3));
			end else if (pick < 92) begin
				r = RW'($urandom);
				draw_circle(cx, cy, r, $urandom_range(0, 5));
			end else begin
				offer_word(OP_STEP, cx, cy, RW'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		// let the checker take in the last word before reading its backlog
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
